// ===== hw/rtl/tlch_pkg.sv =====
package tlch_pkg;

   localparam int LAG_DEPTH      = 16;
   localparam int INPUT_COUNT    = 24;
   localparam int BUNCH_BINS     = 3564;
   localparam int BIN_W          = 12;
   localparam int DIST_W         = 21;
   localparam int INPUT_SHIFT    = 8;
   localparam int TRIG_OFFSET    = 7;
   localparam int TRIG_MAX       = 24;

   localparam logic [2:0] KIND_WORD      = 3'd0;
   localparam logic [2:0] KIND_READ_LAG  = 3'd1;
   localparam logic [2:0] KIND_READ_BIN  = 3'd2;
   localparam logic [2:0] KIND_NEW_SNAP  = 3'd3;
   localparam logic [2:0] KIND_CLEAR     = 3'd4;

   localparam logic CSR_TRIGGER_CHANNEL = 1'b0;
   localparam logic CSR_BUNCH_BIAS      = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUMP,
      ST_READ
   } state_type;

   // Control broadcast to every lag cell.
   typedef struct packed {
      logic       snap_clear;
      logic       hist_clear;
      logic       shift;
      logic       trigger;
      logic [4:0] rd_channel;
   } lag_ctl_type;

endpackage

// ===== hw/rtl/tlch_lag_cell.sv =====
module tlch_lag_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tlch_pkg::lag_ctl_type ctl,
   input  logic [23:0]          word_in,
   input  logic                 valid_in,
   output logic [23:0]          word_out,
   output logic                 valid_out,
   output logic [31:0]          rd_value
);

   logic [23:0] word_ff;
   logic        valid_ff;
   logic [31:0] count_ff [tlch_pkg::INPUT_COUNT];
   logic [31:0] count_in [tlch_pkg::INPUT_COUNT];

   // Each cell holds the inputs of the word one position older than its
   // neighbor, and counts its own lag row when the trigger fires.
   always_comb begin
      for (int c = 0; c < tlch_pkg::INPUT_COUNT; c++) begin
         count_in[c] = count_ff[c];
         if (ctl.shift && ctl.trigger && valid_in && word_in[c] &&
             count_ff[c] != 32'hFFFF_FFFF) begin
            count_in[c] = count_ff[c] + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.hist_clear) begin
         for (int c = 0; c < tlch_pkg::INPUT_COUNT; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < tlch_pkg::INPUT_COUNT; c++) begin
            count_ff[c] <= count_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.snap_clear) begin
         word_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         word_ff  <= word_in;
         valid_ff <= valid_in;
      end
   end

   assign word_out  = word_ff;
   assign valid_out = valid_ff;
   assign rd_value  = (ctl.rd_channel < 5'(tlch_pkg::INPUT_COUNT)) ?
                      count_ff[ctl.rd_channel] : 32'd0;

endmodule

// ===== hw/rtl/trigger_lag_correlation_histogram_unit.sv =====
// Lag counters update in the cycle a word beat is accepted; a word that
// adds a bunch count also reads the bin, then writes it back in the bump
// state. Lag reads answer in the cycle after the request, bunch bin reads
// via the memory output register and the read state. One item is in
// flight at a time, and a result must be taken before the next request.
// After reset or a clear the bunch memory is swept; no request is accepted.
module trigger_lag_correlation_histogram_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_sample_word,
   input  logic [3:0]  req_lag,
   input  logic [4:0]  req_channel,
   input  logic [11:0] req_bunch_bin,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_value,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int BW = tlch_pkg::BIN_W;
   localparam int DW = tlch_pkg::DIST_W;

   tlch_pkg::state_type state_ff, state_in;
   tlch_pkg::lag_ctl_type ctl;

   logic [4:0]    trig_chan_ff;
   logic [5:0]    bias_ff;
   logic          pos_nonzero_ff;
   logic          orbit_seen_ff;
   logic [DW-1:0] dist_ff;
   logic          orbit_seen_in;
   logic [DW-1:0] dist_in;
   logic [BW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [BW-1:0] addr_ff, addr_in;
   logic          oor_ff, oor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;

   logic [31:0]   bunch_mem [tlch_pkg::BUNCH_BINS];
   logic [31:0]   mem_q;
   logic          mem_re, mem_we;
   logic [BW-1:0] mem_ra, mem_wa;
   logic [31:0]   mem_wd;

   logic          accept, is_word, trig_hit;
   logic [5:0]    trig_bit;
   logic [DW:0]   bunch_idx;

   logic [23:0]   chain_word  [tlch_pkg::LAG_DEPTH+1];
   logic          chain_valid [tlch_pkg::LAG_DEPTH+1];
   logic [31:0]   cell_rd     [tlch_pkg::LAG_DEPTH];

   assign accept  = req_valid && req_ready;
   assign is_word = req_kind == tlch_pkg::KIND_WORD;

   assign trig_bit = 6'(trig_chan_ff) + 6'(tlch_pkg::TRIG_OFFSET);
   assign trig_hit = (trig_chan_ff <= 5'(tlch_pkg::TRIG_MAX)) &&
                     req_sample_word[trig_bit[4:0]];

   // Orbit distance as seen by this word, the word itself included.
   always_comb begin
      orbit_seen_in = orbit_seen_ff;
      dist_in       = dist_ff;
      if (req_sample_word[0] && pos_nonzero_ff) begin
         orbit_seen_in = 1'b1;
         dist_in       = '0;
      end else if (orbit_seen_ff && dist_ff != {DW{1'b1}}) begin
         dist_in = dist_ff + DW'(1);
      end
   end

   assign bunch_idx = (DW+1)'(dist_in) + (DW+1)'(bias_ff);

   always_comb begin
      ctl.snap_clear = accept && req_kind == tlch_pkg::KIND_NEW_SNAP;
      ctl.hist_clear = accept && req_kind == tlch_pkg::KIND_CLEAR;
      ctl.shift      = accept && is_word;
      ctl.trigger    = trig_hit;
      ctl.rd_channel = req_channel;
   end

   assign chain_word[0]  = req_sample_word[31:tlch_pkg::INPUT_SHIFT];
   assign chain_valid[0] = 1'b1;

   for (genvar k = 0; k < tlch_pkg::LAG_DEPTH; k++) begin : g_cell
      tlch_lag_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .word_in   (chain_word[k]),
         .valid_in  (chain_valid[k]),
         .word_out  (chain_word[k+1]),
         .valid_out (chain_valid[k+1]),
         .rd_value  (cell_rd[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      addr_in      = addr_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mem_re       = 1'b0;
      mem_ra       = req_bunch_bin;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = '0;
      case (state_ff)
         tlch_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + BW'(1);
            if (clr_cnt_ff == BW'(tlch_pkg::BUNCH_BINS - 1)) begin
               clr_cnt_in = '0;
               state_in   = tlch_pkg::ST_IDLE;
            end
         end
         tlch_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (accept) begin
               case (req_kind)
                  tlch_pkg::KIND_WORD: begin
                     if (trig_hit && orbit_seen_in &&
                         bunch_idx < (DW+1)'(tlch_pkg::BUNCH_BINS)) begin
                        mem_re   = 1'b1;
                        mem_ra   = bunch_idx[BW-1:0];
                        addr_in  = bunch_idx[BW-1:0];
                        state_in = tlch_pkg::ST_BUMP;
                     end
                  end
                  tlch_pkg::KIND_READ_LAG: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = cell_rd[req_lag];
                  end
                  tlch_pkg::KIND_READ_BIN: begin
                     oor_in   = req_bunch_bin >= BW'(tlch_pkg::BUNCH_BINS);
                     mem_re   = !oor_in;
                     state_in = tlch_pkg::ST_READ;
                  end
                  tlch_pkg::KIND_CLEAR: begin
                     state_in = tlch_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tlch_pkg::ST_BUMP: begin
            mem_we   = 1'b1;
            mem_wd   = (mem_q == 32'hFFFF_FFFF) ? mem_q : mem_q + 32'd1;
            state_in = tlch_pkg::ST_IDLE;
         end
         tlch_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = oor_ff ? 32'd0 : mem_q;
            state_in     = tlch_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bunch_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q <= bunch_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlch_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_chan_ff <= 5'd1;
         bias_ff      <= 6'd33;
      end else if (csr_write_enable) begin
         if (csr_index == tlch_pkg::CSR_TRIGGER_CHANNEL) begin
            trig_chan_ff <= csr_wdata[4:0];
         end else begin
            bias_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.snap_clear) begin
         pos_nonzero_ff <= 1'b0;
         orbit_seen_ff  <= 1'b0;
         dist_ff        <= '0;
      end else if (ctl.shift) begin
         pos_nonzero_ff <= 1'b1;
         orbit_seen_ff  <= orbit_seen_in;
         dist_ff        <= dist_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_data_ff;

endmodule

// ===== hw/rtl/tlch_checker.sv =====
module tlch_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_value
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("result beat dropped or changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_lag_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == tlch_pkg::KIND_READ_LAG |=> rsp_valid)
      else $error("lag read gave no result");

   a_word_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == tlch_pkg::KIND_WORD |=> !rsp_valid)
      else $error("word beat produced a result");

endmodule

bind trigger_lag_correlation_histogram_unit tlch_checker u_tlch_checker (.*);

// ===== test/trigger_lag_correlation_histogram_unit_tb.sv =====
`timescale 1ns / 1ps

module trigger_lag_correlation_histogram_unit_tb;

   localparam int WATCHDOG_LIMIT = 30000;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [2:0] KIND_TOP = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] word;
      logic [3:0]  lag;
      logic [4:0]  chan;
      logic [11:0] bin;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_sample_word = '0;
   logic [3:0]  req_lag = '0;
   logic [4:0]  req_channel = '0;
   logic [11:0] req_bunch_bin = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_value;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [5:0]  csr_wdata = '0;

   trigger_lag_correlation_histogram_unit u_top (.*);

   // Shadow of the block's configuration and counting state.
   logic [4:0]  cfg_trig = 5'd1;
   logic [5:0]  cfg_bias = 6'd33;
   logic [23:0] lag_window [tlch_pkg::LAG_DEPTH-1];
   int          window_fill;
   logic        pos_nonzero;
   logic        orbit_seen;
   logic [20:0] orbit_dist;
   logic [31:0] lag_count [tlch_pkg::LAG_DEPTH][tlch_pkg::INPUT_COUNT];
   logic [31:0] bunch_count [tlch_pkg::BUNCH_BINS];

   beat_type    pending_beats[$];
   logic [31:0] expected_reads[$];
   int          tx_idle = 0;
   int          rx_idle = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;

   initial forever #5 clock = ~clock;

   function void restart_snapshot();
      foreach (lag_window[k]) lag_window[k] = '0;
      window_fill = 0;
      pos_nonzero = 0;
      orbit_seen = 0;
      orbit_dist = '0;
   endfunction

   function void clear_counts();
      foreach (lag_count[l, c]) lag_count[l][c] = '0;
      foreach (bunch_count[b]) bunch_count[b] = '0;
   endfunction

   function void count_row(int row, logic [23:0] inputs);
      for (int c = 0; c < tlch_pkg::INPUT_COUNT; c++)
         if (inputs[c] && lag_count[row][c] != '1) lag_count[row][c]++;
   endfunction

   function void take_sample(logic [31:0] w);
      int idx;
      if (w[0] && pos_nonzero) begin
         orbit_seen = 1;
         orbit_dist = '0;
      end else if (orbit_seen && orbit_dist != '1) begin
         orbit_dist++;
      end
      if (cfg_trig <= tlch_pkg::TRIG_MAX && w[cfg_trig + tlch_pkg::TRIG_OFFSET]) begin
         if (orbit_seen) begin
            idx = int'(orbit_dist) + int'(cfg_bias);
            if (idx < tlch_pkg::BUNCH_BINS && bunch_count[idx] != '1) bunch_count[idx]++;
         end
         count_row(0, w[31:tlch_pkg::INPUT_SHIFT]);
         for (int k = 1; k < tlch_pkg::LAG_DEPTH && k <= window_fill; k++)
            count_row(k, lag_window[k-1]);
      end
      for (int k = tlch_pkg::LAG_DEPTH - 2; k > 0; k--) lag_window[k] = lag_window[k-1];
      lag_window[0] = w[31:tlch_pkg::INPUT_SHIFT];
      if (window_fill < tlch_pkg::LAG_DEPTH - 1) window_fill++;
      pos_nonzero = 1;
   endfunction

   function void predict(beat_type b);
      case (b.kind)
         tlch_pkg::KIND_WORD: take_sample(b.word);
         tlch_pkg::KIND_READ_LAG:
            expected_reads.push_back((b.chan < tlch_pkg::INPUT_COUNT) ?
                                     lag_count[b.lag][b.chan] : '0);
         tlch_pkg::KIND_READ_BIN:
            expected_reads.push_back((b.bin < tlch_pkg::BUNCH_BINS) ?
                                     bunch_count[b.bin] : '0);
         tlch_pkg::KIND_NEW_SNAP: restart_snapshot();
         tlch_pkg::KIND_CLEAR: clear_counts();
         default: ;
      endcase
   endfunction

   // Sender: a new beat is offered only once the previous one is taken.
   always @(posedge clock) begin
      beat_type b;
      if (!reset && req_valid && req_ready) begin
         b.kind = req_kind;
         b.word = req_sample_word;
         b.lag = req_lag;
         b.chan = req_channel;
         b.bin = req_bunch_bin;
         predict(b);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle) begin
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_kind <= b.kind;
            req_sample_word <= b.word;
            req_lag <= b.lag;
            req_channel <= b.chan;
            req_bunch_bin <= b.bin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected read beat: %h", rsp_read_value);
         end else begin
            want = expected_reads.pop_front();
            if (want !== rsp_read_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("read_value mismatch: expected %h, got %h", want, rsp_read_value);
            end
         end
      end
      if (hold_req && !hold_done) begin
         hold_done <= 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function beat_type any_beat(logic [2:0] kind);
      beat_type b;
      b.kind = kind;
      b.word = $urandom;
      b.lag = 4'($urandom_range(15));
      b.chan = 5'($urandom_range(31));
      b.bin = 12'($urandom_range(4095));
      return b;
   endfunction

   function void add_word(logic [31:0] w);
      beat_type b;
      b = any_beat(tlch_pkg::KIND_WORD);
      b.word = w;
      pending_beats.push_back(b);
   endfunction

   function void add_lag_read(int lag, int chan);
      beat_type b;
      b = any_beat(tlch_pkg::KIND_READ_LAG);
      b.lag = 4'(lag);
      b.chan = 5'(chan);
      pending_beats.push_back(b);
   endfunction

   function void add_bin_read(int bin);
      beat_type b;
      b = any_beat(tlch_pkg::KIND_READ_BIN);
      b.bin = 12'(bin);
      pending_beats.push_back(b);
   endfunction

   function logic [31:0] trig_word(bit fire);
      logic [31:0] w;
      w = $urandom;
      w[0] = ($urandom_range(11) == 0);
      if (cfg_trig <= tlch_pkg::TRIG_MAX) w[cfg_trig + tlch_pkg::TRIG_OFFSET] = fire;
      return w;
   endfunction

   function void add_reads(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) begin
            add_lag_read($urandom_range(15),
                         ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(23));
         end else begin
            add_bin_read(($urandom_range(4) == 0) ? $urandom_range(4095)
                         : int'(cfg_bias) + $urandom_range(45));
         end
      end
   endfunction

   // Mostly well-formed snapshots followed by reads, with some noise.
   task automatic fill_random(int n);
      int added = 0;
      int r, len;
      while (added < n) begin
         r = $urandom_range(99);
         if (r < 55) begin
            pending_beats.push_back(any_beat(tlch_pkg::KIND_NEW_SNAP));
            len = $urandom_range(4, 40);
            for (int i = 0; i < len; i++) add_word(trig_word($urandom_range(99) < 35));
            r = $urandom_range(3, 8);
            add_reads(r);
            added += len + r + 1;
         end else if (r < 90) begin
            r = $urandom_range(1, 6);
            add_reads(r);
            added += r;
         end else if (r < 92) begin
            pending_beats.push_back(any_beat(tlch_pkg::KIND_CLEAR));
            added++;
         end else if (r < 96) begin
            pending_beats.push_back(
               any_beat(3'($urandom_range(tlch_pkg::KIND_CLEAR + 1, KIND_TOP))));
            added++;
         end else begin
            add_word($urandom);
            added++;
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_reads.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [5:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == tlch_pkg::CSR_TRIGGER_CHANNEL) cfg_trig = value[4:0];
      else cfg_bias = value;
   endtask

   initial begin
      restart_snapshot();
      clear_counts();
      tx_idle = 7;
      rx_idle = 72;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: orbit at position zero, full words, edges of every read.
      add_word(32'h0000_0101);
      add_word(32'h0000_0001);
      add_word(32'hFFFF_FF00);
      add_word(32'h0000_0100);
      add_lag_read(0, 0);
      add_lag_read(15, 23);
      add_lag_read(1, 0);
      add_lag_read(0, 31);
      add_lag_read(2, 24);
      add_bin_read(33);
      add_bin_read(34);
      add_bin_read(35);
      add_bin_read(3563);
      add_bin_read(4095);
      pending_beats.push_back(any_beat(KIND_TOP - 3'd2));
      pending_beats.push_back(any_beat(KIND_TOP - 3'd1));
      pending_beats.push_back(any_beat(KIND_TOP));
      pending_beats.push_back(any_beat(tlch_pkg::KIND_NEW_SNAP));
      add_word(32'hFFFF_FFFF);
      add_lag_read(0, 23);
      pending_beats.push_back(any_beat(tlch_pkg::KIND_CLEAR));
      add_bin_read(33);
      add_lag_read(0, 0);
      drain();

      write_csr(tlch_pkg::CSR_TRIGGER_CHANNEL, 6'd0);
      write_csr(tlch_pkg::CSR_BUNCH_BIAS, 6'd0);
      fill_random(300);
      drain();
      write_csr(tlch_pkg::CSR_TRIGGER_CHANNEL, 6'd24);
      write_csr(tlch_pkg::CSR_BUNCH_BIAS, 6'd63);
      fill_random(300);
      drain();

      tx_idle = 72;
      rx_idle = 7;
      // Bit 5 of the write data is dropped, leaving channel 31: never triggers.
      write_csr(tlch_pkg::CSR_TRIGGER_CHANNEL, 6'h3F);
      write_csr(tlch_pkg::CSR_BUNCH_BIAS, 6'd17);
      fill_random(150);
      drain();
      write_csr(tlch_pkg::CSR_TRIGGER_CHANNEL, 6'd13);
      write_csr(tlch_pkg::CSR_BUNCH_BIAS, 6'd33);
      fill_random(300);
      drain();

      tx_idle = 0;
      rx_idle = 0;
      write_csr(tlch_pkg::CSR_TRIGGER_CHANNEL, 6'd5);
      write_csr(tlch_pkg::CSR_BUNCH_BIAS, 6'd63);
      hold_req = 1;
      pending_beats.push_back(any_beat(tlch_pkg::KIND_NEW_SNAP));
      add_word(32'h0000_0000);
      add_word(32'h0000_0001);
      add_word(trig_word(1) & ~32'h1);
      add_bin_read(3563);
      add_lag_read(0, 4);
      fill_random(350);
      drain();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_reads.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
